[src/dpds_pkg.sv]
// Shared types and constants for the dual PID differential steering block.
package dpds_pkg;

    localparam int SPEED_W    = 15;
    localparam int GAIN_W     = 32;
    localparam int ERR_W      = 16;
    localparam int INT_W      = 32;
    localparam int TERM_W     = 64;
    localparam int FRAC_SHIFT = 16;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic signed [ERR_W-1:0]  ANGLE_WINDOW = 16'sd70;
    localparam logic signed [ERR_W-1:0]  DISP_WINDOW  = 16'sd320;
    localparam logic signed [ERR_W:0]    DISP_BIAS    = 17'sd20;

    localparam logic [SPEED_W-1:0]       BASE_SPEED_RST = 15'd8192;
    localparam logic [SPEED_W-1:0]       SPEED_MAX_RST  = 15'd19661;
    localparam logic signed [GAIN_W-1:0] ANGLE_KP_RST   = 32'sd2147484;
    localparam logic signed [GAIN_W-1:0] ANGLE_KI_RST   = 32'sd0;
    localparam logic signed [GAIN_W-1:0] ANGLE_KD_RST   = 32'sd42950;
    localparam logic signed [GAIN_W-1:0] DISP_KP_RST    = 32'sd254477;
    localparam logic signed [GAIN_W-1:0] DISP_KI_RST    = 32'sd0;
    localparam logic signed [GAIN_W-1:0] DISP_KD_RST    = 32'sd80531;

    typedef enum logic [2:0] {
        REG_BASE_SPEED = 3'd0,
        REG_SPEED_MAX  = 3'd1,
        REG_ANGLE_KP   = 3'd2,
        REG_ANGLE_KI   = 3'd3,
        REG_ANGLE_KD   = 3'd4,
        REG_DISP_KP    = 3'd5,
        REG_DISP_KI    = 3'd6,
        REG_DISP_KD    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [SPEED_W-1:0]       base_speed;
        logic [SPEED_W-1:0]       speed_max;
        logic signed [GAIN_W-1:0] angle_kp;
        logic signed [GAIN_W-1:0] angle_ki;
        logic signed [GAIN_W-1:0] angle_kd;
        logic signed [GAIN_W-1:0] disp_kp;
        logic signed [GAIN_W-1:0] disp_ki;
        logic signed [GAIN_W-1:0] disp_kd;
    } cfg_t;

endpackage

[src/dpds_regs.sv]
// APB configuration register file for the steering block.
module dpds_regs
    import dpds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_BASE_SPEED: cfg_next.base_speed = pwdata[SPEED_W-1:0];
                REG_SPEED_MAX:  cfg_next.speed_max  = pwdata[SPEED_W-1:0];
                REG_ANGLE_KP:   cfg_next.angle_kp   = $signed(pwdata);
                REG_ANGLE_KI:   cfg_next.angle_ki   = $signed(pwdata);
                REG_ANGLE_KD:   cfg_next.angle_kd   = $signed(pwdata);
                REG_DISP_KP:    cfg_next.disp_kp    = $signed(pwdata);
                REG_DISP_KI:    cfg_next.disp_ki    = $signed(pwdata);
                REG_DISP_KD:    cfg_next.disp_kd    = $signed(pwdata);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BASE_SPEED: prdata = {{(DATA_W-SPEED_W){1'b0}}, cfg_reg.base_speed};
            REG_SPEED_MAX:  prdata = {{(DATA_W-SPEED_W){1'b0}}, cfg_reg.speed_max};
            REG_ANGLE_KP:   prdata = cfg_reg.angle_kp;
            REG_ANGLE_KI:   prdata = cfg_reg.angle_ki;
            REG_ANGLE_KD:   prdata = cfg_reg.angle_kd;
            REG_DISP_KP:    prdata = cfg_reg.disp_kp;
            REG_DISP_KI:    prdata = cfg_reg.disp_ki;
            REG_DISP_KD:    prdata = cfg_reg.disp_kd;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed <= BASE_SPEED_RST;
            cfg_reg.speed_max  <= SPEED_MAX_RST;
            cfg_reg.angle_kp   <= ANGLE_KP_RST;
            cfg_reg.angle_ki   <= ANGLE_KI_RST;
            cfg_reg.angle_kd   <= ANGLE_KD_RST;
            cfg_reg.disp_kp    <= DISP_KP_RST;
            cfg_reg.disp_ki    <= DISP_KI_RST;
            cfg_reg.disp_kd    <= DISP_KD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/dual_pid_differential_steer.sv]
// An accepted input word passes through the input, integrator, multiply and sum registers to the output register.
// Throughput: one word per cycle; the five-stage pipeline advances as a whole
// whenever the output register is empty or its word is taken.
// Stages: input, integrator update, gain multiplies, term sums, speed mix and clamp.
// Reset: gains and speed limits return to defaults, loop state and held speeds to zero.
// Top level of the dual PID differential steering block.
module dual_pid_differential_steer
    import dpds_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ERR_W-1:0]  heading_error,
    input  logic signed [ERR_W-1:0]  lateral_offset,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [SPEED_W-1:0]       left_speed,
    output logic [SPEED_W-1:0]       right_speed,
    output logic                     speeds_updated
);

    cfg_t cfg;

    dpds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic adv;

    // stage 1: input register
    logic                     v1_reg;
    logic signed [ERR_W-1:0]  ang1_reg;
    logic signed [ERR_W-1:0]  off1_reg;

    // loop state
    logic signed [ERR_W-1:0]  angle_prev_reg;
    logic signed [INT_W-1:0]  angle_int_reg;
    logic signed [TERM_W-1:0] angle_term_reg;
    logic signed [ERR_W:0]    disp_prev_reg;
    logic signed [INT_W-1:0]  disp_int_reg;
    logic [SPEED_W-1:0]       left_hold_reg;
    logic [SPEED_W-1:0]       right_hold_reg;

    // stage 2
    logic                     v2_reg;
    logic                     a_win2_reg;
    logic                     d_win2_reg;
    logic signed [ERR_W-1:0]  a_err2_reg;
    logic signed [INT_W-1:0]  a_int2_reg;
    logic signed [ERR_W:0]    a_diff2_reg;
    logic signed [ERR_W:0]    d_err2_reg;
    logic signed [INT_W-1:0]  d_int2_reg;
    logic signed [ERR_W+1:0]  d_diff2_reg;

    // stage 3
    logic                     v3_reg;
    logic                     a_win3_reg;
    logic                     d_win3_reg;
    logic signed [47:0]       a_pp3_reg;
    logic signed [63:0]       a_pi3_reg;
    logic signed [48:0]       a_pd3_reg;
    logic signed [48:0]       d_pp3_reg;
    logic signed [63:0]       d_pi3_reg;
    logic signed [49:0]       d_pd3_reg;

    // stage 4
    logic                     v4_reg;
    logic                     d_win4_reg;
    logic signed [TERM_W-1:0] aterm4_reg;
    logic signed [TERM_W-1:0] dterm4_reg;

    // stage 5: output register
    logic                     out_valid_reg;
    logic [SPEED_W-1:0]       left_reg;
    logic [SPEED_W-1:0]       right_reg;
    logic                     upd_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign left_speed     = left_reg;
    assign right_speed    = right_reg;
    assign speeds_updated = upd_reg;

    // integrator update
    logic                     a_win;
    logic                     d_win;
    logic signed [ERR_W:0]    d_err;
    logic signed [INT_W:0]    a_sum;
    logic signed [INT_W:0]    d_sum;
    logic signed [INT_W-1:0]  a_int_next;
    logic signed [INT_W-1:0]  d_int_next;
    logic signed [ERR_W:0]    a_diff;
    logic signed [ERR_W+1:0]  d_diff;

    assign a_win = (ang1_reg < ANGLE_WINDOW) && (ang1_reg > -ANGLE_WINDOW);
    assign d_win = (off1_reg < DISP_WINDOW) && (off1_reg > -DISP_WINDOW);
    assign d_err = (ERR_W+1)'(off1_reg) + DISP_BIAS;
    assign a_sum = (INT_W+1)'(angle_int_reg) + (INT_W+1)'(ang1_reg);
    assign d_sum = (INT_W+1)'(disp_int_reg) + (INT_W+1)'(d_err);
    assign a_diff = (ERR_W+1)'(ang1_reg) - (ERR_W+1)'(angle_prev_reg);
    assign d_diff = (ERR_W+2)'(d_err) - (ERR_W+2)'(disp_prev_reg);

    always_comb
    begin
        if (a_sum[INT_W] != a_sum[INT_W-1])
            a_int_next = a_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
        else
            a_int_next = a_sum[INT_W-1:0];
        if (d_sum[INT_W] != d_sum[INT_W-1])
            d_int_next = d_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
        else
            d_int_next = d_sum[INT_W-1:0];
    end

    // term sums
    logic signed [TERM_W-1:0] a_term_sum;
    logic signed [TERM_W-1:0] d_term_sum;
    logic signed [TERM_W-1:0] aterm_next;

    assign a_term_sum = TERM_W'(a_pp3_reg) + a_pi3_reg + TERM_W'(a_pd3_reg);
    assign d_term_sum = TERM_W'(d_pp3_reg) + d_pi3_reg + TERM_W'(d_pd3_reg);
    assign aterm_next = a_win3_reg ? a_term_sum : angle_term_reg;

    // speed mix and clamp
    logic signed [TERM_W:0]   mix_sum;
    logic signed [TERM_W-FRAC_SHIFT:0] steer;
    logic signed [TERM_W-FRAC_SHIFT+1:0] left_raw;
    logic signed [TERM_W-FRAC_SHIFT+1:0] right_raw;
    logic signed [TERM_W-FRAC_SHIFT+1:0] base_ext;
    logic signed [TERM_W-FRAC_SHIFT+1:0] max_ext;
    logic [SPEED_W-1:0]       left_clamp;
    logic [SPEED_W-1:0]       right_clamp;

    assign mix_sum   = (TERM_W+1)'(aterm4_reg) + (TERM_W+1)'(dterm4_reg);
    assign steer     = mix_sum[TERM_W:FRAC_SHIFT];
    assign base_ext  = $signed({{(TERM_W-FRAC_SHIFT+2-SPEED_W){1'b0}}, cfg.base_speed});
    assign max_ext   = $signed({{(TERM_W-FRAC_SHIFT+2-SPEED_W){1'b0}}, cfg.speed_max});
    assign left_raw  = base_ext + (TERM_W-FRAC_SHIFT+2)'(steer);
    assign right_raw = base_ext - (TERM_W-FRAC_SHIFT+2)'(steer);

    always_comb
    begin
        if (left_raw < 0)
            left_clamp = '0;
        else if (left_raw > max_ext)
            left_clamp = cfg.speed_max;
        else
            left_clamp = left_raw[SPEED_W-1:0];
        if (right_raw < 0)
            right_clamp = '0;
        else if (right_raw > max_ext)
            right_clamp = cfg.speed_max;
        else
            right_clamp = right_raw[SPEED_W-1:0];
    end

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            angle_prev_reg <= '0;
            angle_int_reg  <= '0;
            angle_term_reg <= '0;
            disp_prev_reg  <= '0;
            disp_int_reg   <= '0;
            left_hold_reg  <= '0;
            right_hold_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
            if (v1_reg && a_win)
            begin
                angle_int_reg  <= a_int_next;
                angle_prev_reg <= ang1_reg;
            end
            if (v1_reg && d_win)
            begin
                disp_int_reg  <= d_int_next;
                disp_prev_reg <= d_err;
            end
            if (v3_reg)
                angle_term_reg <= aterm_next;
            if (v4_reg && d_win4_reg)
            begin
                left_hold_reg  <= left_clamp;
                right_hold_reg <= right_clamp;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang1_reg <= heading_error;
            off1_reg <= lateral_offset;

            a_win2_reg  <= a_win;
            d_win2_reg  <= d_win;
            a_err2_reg  <= ang1_reg;
            a_int2_reg  <= a_int_next;
            a_diff2_reg <= a_diff;
            d_err2_reg  <= d_err;
            d_int2_reg  <= d_int_next;
            d_diff2_reg <= d_diff;

            a_win3_reg <= a_win2_reg;
            d_win3_reg <= d_win2_reg;
            a_pp3_reg  <= 48'(cfg.angle_kp) * 48'(a_err2_reg);
            a_pi3_reg  <= 64'(cfg.angle_ki) * 64'(a_int2_reg);
            a_pd3_reg  <= 49'(cfg.angle_kd) * 49'(a_diff2_reg);
            d_pp3_reg  <= 49'(cfg.disp_kp) * 49'(d_err2_reg);
            d_pi3_reg  <= 64'(cfg.disp_ki) * 64'(d_int2_reg);
            d_pd3_reg  <= 50'(cfg.disp_kd) * 50'(d_diff2_reg);

            d_win4_reg <= d_win3_reg;
            aterm4_reg <= aterm_next;
            dterm4_reg <= d_term_sum;

            left_reg  <= d_win4_reg ? left_clamp : left_hold_reg;
            right_reg <= d_win4_reg ? right_clamp : right_hold_reg;
            upd_reg   <= d_win4_reg;
        end
    end

endmodule

[tb/tb.sv]
// Self-checking testbench for the dual PID differential steering block.
`timescale 1ns / 1ps

module tb;
    import dpds_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PHASES = 11;

    typedef struct packed {
        logic signed [ERR_W-1:0] heading;
        logic signed [ERR_W-1:0] lateral;
    } steer_word_t;

    typedef struct packed {
        logic [SPEED_W-1:0] left;
        logic [SPEED_W-1:0] right;
        logic               updated;
    } wheel_cmd_t;

    localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
    localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [ERR_W-1:0] heading_error = '0;
    logic signed [ERR_W-1:0] lateral_offset = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [SPEED_W-1:0]      left_speed;
    logic [SPEED_W-1:0]      right_speed;
    logic                    speeds_updated;

    dual_pid_differential_steer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .heading_error  (heading_error),
        .lateral_offset (lateral_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .speeds_updated (speeds_updated)
    );

    steer_word_t steer_in_q[$];
    wheel_cmd_t  wheel_cmd_q[$];
    steer_word_t next_word;
    wheel_cmd_t  want;
    cfg_t        shadow_cfg;
    bit          no_idle = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;

    logic signed [79:0] ang_prev, ang_int, ang_term;
    logic signed [79:0] disp_prev, disp_int;
    logic [SPEED_W-1:0] left_hold, right_hold;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [79:0] sat32(logic signed [79:0] x);
        if (x > SAT_HI)
            return SAT_HI;
        if (x < SAT_LO)
            return SAT_LO;
        return x;
    endfunction

    function automatic logic [SPEED_W-1:0] clamp_speed(logic signed [79:0] v,
                                                      logic signed [79:0] top);
        if (v < 0)
            return '0;
        if (v > top)
            return top[SPEED_W-1:0];
        return v[SPEED_W-1:0];
    endfunction

    function automatic wheel_cmd_t predict_wheel_speeds(logic signed [ERR_W-1:0] heading,
                                                        logic signed [ERR_W-1:0] lateral);
        logic signed [79:0] a, e, d_term, s, bs, top;
        wheel_cmd_t cmd;
        a = heading;
        e = lateral;
        cmd.updated = 1'b0;
        if (a < 70 && a > -70)
        begin
            ang_int = sat32(ang_int + a);
            ang_term = $signed(shadow_cfg.angle_kp) * a
                     + $signed(shadow_cfg.angle_ki) * ang_int
                     + $signed(shadow_cfg.angle_kd) * (a - ang_prev);
            ang_prev = a;
        end
        if (e < 320 && e > -320)
        begin
            e = e + 20;
            disp_int = sat32(disp_int + e);
            d_term = $signed(shadow_cfg.disp_kp) * e
                   + $signed(shadow_cfg.disp_ki) * disp_int
                   + $signed(shadow_cfg.disp_kd) * (e - disp_prev);
            disp_prev = e;
            s = (d_term + ang_term) >>> FRAC_SHIFT;
            bs = {65'd0, shadow_cfg.base_speed};
            top = {65'd0, shadow_cfg.speed_max};
            left_hold = clamp_speed(bs + s, top);
            right_hold = clamp_speed(bs - s, top);
            cmd.updated = 1'b1;
        end
        cmd.left = left_hold;
        cmd.right = right_hold;
        return cmd;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                wheel_cmd_q.push_back(predict_wheel_speeds(heading_error, lateral_offset));
            if (!in_valid || in_ready)
            begin
                if (steer_in_q.size() != 0 && (no_idle || $urandom_range(99) >= 34))
                begin
                    next_word = steer_in_q.pop_front();
                    in_valid <= 1'b1;
                    heading_error <= next_word.heading;
                    lateral_offset <= next_word.lateral;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (wheel_cmd_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: left=%0d right=%0d updated=%0b",
                                 left_speed, right_speed, speeds_updated);
                end
                else
                begin
                    want = wheel_cmd_q.pop_front();
                    if (left_speed !== want.left || right_speed !== want.right
                        || speeds_updated !== want.updated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: left %0d/%0d right %0d/%0d updated %0b/%0b",
                                     want.left, left_speed, want.right, right_speed,
                                     want.updated, speeds_updated);
                    end
                end
            end
            out_ready <= no_idle || $urandom_range(99) >= 34;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BASE_SPEED: shadow_cfg.base_speed = value[SPEED_W-1:0];
            REG_SPEED_MAX:  shadow_cfg.speed_max = value[SPEED_W-1:0];
            REG_ANGLE_KP:   shadow_cfg.angle_kp = value;
            REG_ANGLE_KI:   shadow_cfg.angle_ki = value;
            REG_ANGLE_KD:   shadow_cfg.angle_kd = value;
            REG_DISP_KP:    shadow_cfg.disp_kp = value;
            REG_DISP_KI:    shadow_cfg.disp_ki = value;
            REG_DISP_KD:    shadow_cfg.disp_kd = value;
            default: ;
        endcase
    endtask

    task automatic load_config(cfg_t c);
        write_reg(REG_BASE_SPEED, {17'd0, c.base_speed});
        write_reg(REG_SPEED_MAX, {17'd0, c.speed_max});
        write_reg(REG_ANGLE_KP, c.angle_kp);
        write_reg(REG_ANGLE_KI, c.angle_ki);
        write_reg(REG_ANGLE_KD, c.angle_kd);
        write_reg(REG_DISP_KP, c.disp_kp);
        write_reg(REG_DISP_KI, c.disp_ki);
        write_reg(REG_DISP_KD, c.disp_kd);
    endtask

    task automatic drain;
        while (steer_in_q.size() != 0 || in_valid || wheel_cmd_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] rand_gain();
        int m;
        case ($urandom_range(4))
            0: return $urandom;
            1: m = int'($urandom_range(0, 4194304));
            2: m = int'($urandom_range(0, 262144));
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: m = int'($urandom_range(0, 16));
        endcase
        return $urandom_range(1) ? -m : m;
    endfunction

    function automatic logic [SPEED_W-1:0] rand_speed();
        case ($urandom_range(3))
            0: return '0;
            1: return 15'h7FFF;
            default: return SPEED_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic steer_word_t rand_word();
        steer_word_t w;
        int h, l;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: h = int'($urandom_range(0, 138)) - 69;
            6: h = $urandom_range(1) ? ($urandom_range(1) ? 69 : 70)
                                     : ($urandom_range(1) ? -69 : -70);
            default: h = int'($urandom_range(0, 65535)) - 32768;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: l = int'($urandom_range(0, 638)) - 319;
            7: l = $urandom_range(1) ? ($urandom_range(1) ? 319 : 320)
                                     : ($urandom_range(1) ? -319 : -320);
            default: l = int'($urandom_range(0, 65535)) - 32768;
        endcase
        w.heading = ERR_W'(h);
        w.lateral = ERR_W'(l);
        return w;
    endfunction

    initial
    begin
        cfg_t c;
        steer_word_t w;
        shadow_cfg = '{BASE_SPEED_RST, SPEED_MAX_RST, ANGLE_KP_RST, ANGLE_KI_RST,
                       ANGLE_KD_RST, DISP_KP_RST, DISP_KI_RST, DISP_KD_RST};
        ang_prev = 0;
        ang_int = 0;
        ang_term = 0;
        disp_prev = 0;
        disp_int = 0;
        left_hold = '0;
        right_hold = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        steer_in_q.push_back('{16'sd0, 16'sd0});
        steer_in_q.push_back('{16'sd69, -16'sd20});
        steer_in_q.push_back('{-16'sd69, 16'sd319});
        steer_in_q.push_back('{16'sd70, 16'sd0});
        steer_in_q.push_back('{-16'sd70, -16'sd319});
        steer_in_q.push_back('{16'sd32767, 16'sd320});
        steer_in_q.push_back('{-16'sd32768, -16'sd32768});
        steer_in_q.push_back('{-16'sd32768, 16'sd32767});
        steer_in_q.push_back('{16'sd0, -16'sd320});
        steer_in_q.push_back('{16'sd68, 16'sd318});
        steer_in_q.push_back('{-16'sd1, -16'sd1});
        steer_in_q.push_back('{16'sd1, 16'sd1});
        steer_in_q.push_back('{16'sd69, 16'sd319});
        steer_in_q.push_back('{-16'sd69, -16'sd319});
        steer_in_q.push_back('{16'sd12, 16'sd100});
        steer_in_q.push_back('{-16'sd40, -16'sd200});
        steer_in_q.push_back('{16'sd70, 16'sd320});
        steer_in_q.push_back('{16'sd0, -16'sd21});
        steer_in_q.push_back('{-16'sd21846, 16'sd21845});
        steer_in_q.push_back('{16'sd21845, -16'sd21846});
        drain();

        // saturate both wheels high and low
        c = '{15'h7FFF, 15'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        load_config(c);
        repeat (40) steer_in_q.push_back(rand_word());
        drain();

        c = '{15'd0, 15'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        load_config(c);
        repeat (40) steer_in_q.push_back(rand_word());
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            c.base_speed = rand_speed();
            c.speed_max = rand_speed();
            c.angle_kp = rand_gain();
            c.angle_ki = rand_gain();
            c.angle_kd = rand_gain();
            c.disp_kp = rand_gain();
            c.disp_ki = rand_gain();
            c.disp_kd = rand_gain();
            load_config(c);
            no_idle = (p == 4);
            repeat (p == 4 ? 300 : 125)
            begin
                w = rand_word();
                steer_in_q.push_back(w);
            end
            drain();
            no_idle = 1'b0;
        end

        if (mismatches == 0 && wheel_cmd_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
